FILE: rtl/kbl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbl_pkg: shared types and constants of the k-best list
// Slot layout, memory port structs and word codes used by the list logic.
// ----------------------------------------------------------------------------
package kbl_pkg;

    localparam int K      = 16;
    localparam int NSLOTS = K + 1;
    localparam int SLOT_W = $clog2(K + 1);
    localparam int ID_W   = 32;
    localparam int COST_W = 32;
    localparam int MODE_W = 2;

    typedef logic [SLOT_W-1:0] t_ptr;
    typedef logic [ID_W-1:0]   t_id;
    typedef logic [COST_W-1:0] t_cost;
    typedef logic [MODE_W-1:0] t_mode;

    localparam t_id   EMPTY_ID = '1;
    localparam t_cost INF      = '1;

    localparam t_ptr SCRATCH_SLOT = '0;
    localparam t_ptr FIRST_SLOT   = t_ptr'(1);
    localparam t_ptr LAST_SLOT    = t_ptr'(K);

    localparam t_mode MODE_INSERT = 2'd0;
    localparam t_mode MODE_UPDATE = 2'd1;
    localparam t_mode MODE_READ   = 2'd2;

    typedef struct packed {
        t_id   id;
        t_cost cost;
    } t_slot;

    typedef struct packed {
        logic  en;
        t_ptr  addr;
        t_slot data;
    } t_mem_wr;

    typedef struct packed {
        logic en;
        t_ptr addr;
    } t_mem_rd;

endpackage
`default_nettype wire

FILE: rtl/kbl_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbl_if: word channels of the k-best list
// Candidate input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface kbl_in_if;
    logic           valid;
    logic           ready;
    kbl_pkg::t_mode mode;
    kbl_pkg::t_id   item_id;
    kbl_pkg::t_cost item_cost;

    modport source (output valid, output mode, output item_id, output item_cost,
                    input ready);
    modport sink (input valid, input mode, input item_id, input item_cost,
                  output ready);
endinterface

interface kbl_out_if;
    logic           valid;
    logic           ready;
    kbl_pkg::t_id   out_id;
    kbl_pkg::t_cost out_cost;
    kbl_pkg::t_cost worst_cost;
    logic           last;

    modport source (output valid, output out_id, output out_cost,
                    output worst_cost, output last, input ready);
    modport sink (input valid, input out_id, input out_cost, input worst_cost,
                  input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/k_best_list_insert.sv
`default_nettype none
// ----------------------------------------------------------------------------
// k_best_list_insert: list of the K lowest-cost (id, cost) pairs
// A plain insert bubbles the new entry through the slots before its result word.
// An update searches one slot per cycle for its id, then bubbles from the found
// slot, or from the scratch slot if the id is absent, at one slot per cycle.
// A readout's words pass the memory read and output registers, one word per
// cycle while the sink is ready; the single slot memory port pair sets the rate.
// Reset empties the list at once through per-slot valid bits.
// ----------------------------------------------------------------------------
module k_best_list_insert (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    kbl_in_if.sink     i_in,
    kbl_out_if.source  o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_BUBBLE,
        S_TAIL,
        S_READ,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    kbl_pkg::t_slot   r_carry, n_carry;
    kbl_pkg::t_ptr    r_ptr, n_ptr;
    kbl_pkg::t_cost   r_worst, n_worst;
    logic             r_out_valid, n_out_valid;
    kbl_pkg::t_id     r_out_id, n_out_id;
    kbl_pkg::t_cost   r_out_cost, n_out_cost;
    kbl_pkg::t_cost   r_out_worst, n_out_worst;
    logic             r_out_last, n_out_last;

    kbl_pkg::t_mem_wr w_wr;
    kbl_pkg::t_mem_rd w_rd;
    kbl_pkg::t_slot   w_rd_data;
    logic             w_out_free;
    logic             w_better;
    logic             w_hit;
    kbl_pkg::t_ptr    w_start;

    kbl_slot_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_rd      (w_rd),
        .o_rd_data (w_rd_data)
    );

    // The carried entry beats the stored one on lower cost, then on smaller id.
    assign w_better = (r_carry.cost < w_rd_data.cost) ||
                      ((r_carry.cost == w_rd_data.cost) && (r_carry.id < w_rd_data.id));
    assign w_hit      = (w_rd_data.id == r_carry.id);
    assign w_start    = w_hit ? r_ptr : kbl_pkg::SCRATCH_SLOT;
    assign w_out_free = !r_out_valid || o_out.ready;

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.out_id     = r_out_id;
    assign o_out.out_cost   = r_out_cost;
    assign o_out.worst_cost = r_out_worst;
    assign o_out.last       = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_carry     = r_carry;
        n_ptr       = r_ptr;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_id    = r_out_id;
        n_out_cost  = r_out_cost;
        n_out_worst = r_out_worst;
        n_out_last  = r_out_last;
        w_wr        = '0;
        w_rd        = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_carry = '{id: i_in.item_id, cost: i_in.item_cost};
                    unique case (i_in.mode)
                        kbl_pkg::MODE_INSERT: begin
                            w_rd    = '{en: 1'b1, addr: kbl_pkg::FIRST_SLOT};
                            n_ptr   = kbl_pkg::FIRST_SLOT;
                            n_state = S_BUBBLE;
                        end
                        kbl_pkg::MODE_UPDATE: begin
                            w_rd    = '{en: 1'b1, addr: kbl_pkg::SCRATCH_SLOT};
                            n_ptr   = kbl_pkg::SCRATCH_SLOT;
                            n_state = S_SEARCH;
                        end
                        kbl_pkg::MODE_READ: begin
                            w_rd    = '{en: 1'b1, addr: kbl_pkg::LAST_SLOT};
                            n_ptr   = kbl_pkg::LAST_SLOT;
                            n_state = S_READ;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (w_hit || (r_ptr == kbl_pkg::LAST_SLOT)) begin
                    if (w_start == kbl_pkg::LAST_SLOT) begin
                        n_state = S_TAIL;
                    end else begin
                        w_rd    = '{en: 1'b1, addr: w_start + kbl_pkg::FIRST_SLOT};
                        n_ptr   = w_start + kbl_pkg::FIRST_SLOT;
                        n_state = S_BUBBLE;
                    end
                end else begin
                    w_rd  = '{en: 1'b1, addr: r_ptr + kbl_pkg::FIRST_SLOT};
                    n_ptr = r_ptr + kbl_pkg::FIRST_SLOT;
                end
            end
            S_BUBBLE: begin
                w_wr.en   = 1'b1;
                w_wr.addr = r_ptr - kbl_pkg::FIRST_SLOT;
                if (w_better) begin
                    w_wr.data = w_rd_data;
                end else begin
                    w_wr.data = r_carry;
                    n_carry   = w_rd_data;
                end
                if (r_ptr == kbl_pkg::LAST_SLOT) begin
                    n_state = S_TAIL;
                end else begin
                    w_rd  = '{en: 1'b1, addr: r_ptr + kbl_pkg::FIRST_SLOT};
                    n_ptr = r_ptr + kbl_pkg::FIRST_SLOT;
                end
            end
            S_TAIL: begin
                w_wr    = '{en: 1'b1, addr: kbl_pkg::LAST_SLOT, data: r_carry};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_id    = '0;
                    n_out_cost  = '0;
                    n_out_worst = r_worst;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_READ: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_id    = w_rd_data.id;
                    n_out_cost  = w_rd_data.cost;
                    n_out_worst = r_worst;
                    n_out_last  = (r_ptr == kbl_pkg::FIRST_SLOT);
                    if (r_ptr == kbl_pkg::FIRST_SLOT) begin
                        n_state = S_IDLE;
                    end else begin
                        w_rd  = '{en: 1'b1, addr: r_ptr - kbl_pkg::FIRST_SLOT};
                        n_ptr = r_ptr - kbl_pkg::FIRST_SLOT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_worst = r_worst;
        if (w_wr.en && (w_wr.addr == kbl_pkg::SCRATCH_SLOT)) begin
            n_worst = w_wr.data.cost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_worst     <= kbl_pkg::INF;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_worst     <= n_worst;
        end
        r_carry     <= n_carry;
        r_ptr       <= n_ptr;
        r_out_id    <= n_out_id;
        r_out_cost  <= n_out_cost;
        r_out_worst <= n_out_worst;
        r_out_last  <= n_out_last;
    end

    a_bubble_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BUBBLE) |->
            ((r_ptr >= kbl_pkg::FIRST_SLOT) && (r_ptr <= kbl_pkg::LAST_SLOT)))
        else $error("bubble pointer outside the ordered slots");

    a_read_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |->
            ((r_ptr >= kbl_pkg::FIRST_SLOT) && (r_ptr <= kbl_pkg::LAST_SLOT)))
        else $error("readout pointer outside the ordered slots");

    a_inner_word_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_state == S_READ))
        else $error("non-final result word outside a readout");

endmodule
`default_nettype wire

FILE: rtl/kbl_slot_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbl_slot_mem: slot memory of the k-best list
// One write port and one registered read port. Per-slot valid bits make a
// slot that was never written read back as empty with infinite cost.
// ----------------------------------------------------------------------------
module kbl_slot_mem (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire kbl_pkg::t_mem_wr i_wr,
    input  wire kbl_pkg::t_mem_rd i_rd,
    output kbl_pkg::t_slot        o_rd_data
);

    kbl_pkg::t_slot              r_mem [0:kbl_pkg::NSLOTS-1];
    logic [kbl_pkg::NSLOTS-1:0]  r_valid;
    kbl_pkg::t_slot              r_rd_data;
    logic                        r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_hit <= r_valid[i_rd.addr];
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data
                                : kbl_pkg::t_slot'{id: kbl_pkg::EMPTY_ID, cost: kbl_pkg::INF};

    // The list logic always reads ahead of the slot it writes.
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr.en && i_rd.en && (i_wr.addr == i_rd.addr)))
        else $error("slot read and write hit the same address");

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.en |-> (i_wr.addr <= kbl_pkg::LAST_SLOT))
        else $error("slot write beyond the list");

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd.en |-> (i_rd.addr <= kbl_pkg::LAST_SLOT))
        else $error("slot read beyond the list");

endmodule
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the k-best list
// Candidate words go in through a queued driver and every result word is
// checked against a behavioral copy of the list: directed corner words first,
// then random inserts, updates and readouts under varying idle and stall rates.
// ----------------------------------------------------------------------------
module tb;

    localparam kbl_pkg::t_mode MODE_UNUSED = 2'd3;

    typedef struct packed {
        kbl_pkg::t_mode mode;
        kbl_pkg::t_id   id;
        kbl_pkg::t_cost cost;
    } t_cand;

    typedef struct packed {
        kbl_pkg::t_id   id;
        kbl_pkg::t_cost cost;
        kbl_pkg::t_cost worst;
        logic           last;
    } t_list_word;

    logic i_clk;
    logic i_rst_n;

    kbl_in_if  in_ch ();
    kbl_out_if out_ch ();

    k_best_list_insert uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_cand          pending_cands[$];
    t_list_word     due_words[$];
    kbl_pkg::t_id   issued_ids[$];
    kbl_pkg::t_id   list_id[kbl_pkg::NSLOTS];
    kbl_pkg::t_cost list_cost[kbl_pkg::NSLOTS];
    int             fault_count   = 0;
    int             send_idle_pct = 0;
    int             rx_stall_pct  = 0;
    int             rx_hold_left  = 0;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic bit ranks_above(int a, int b);
        if (list_cost[a] != list_cost[b]) return list_cost[a] < list_cost[b];
        return list_id[a] < list_id[b];
    endfunction

    function automatic void add_due(t_list_word w);
        due_words = {due_words, w};
    endfunction

    // Applies one accepted candidate word to the list copy and queues the
    // result words it must produce.
    function automatic void apply_word(kbl_pkg::t_mode mode, kbl_pkg::t_id id,
                                       kbl_pkg::t_cost cost);
        int             start;
        kbl_pkg::t_id   tid;
        kbl_pkg::t_cost tcost;
        t_list_word     w;
        start = 0;
        case (mode)
            kbl_pkg::MODE_INSERT, kbl_pkg::MODE_UPDATE: begin
                if (mode == kbl_pkg::MODE_UPDATE) begin
                    for (int k = kbl_pkg::NSLOTS - 1; k >= 0; k--) begin
                        if (list_id[k] == id) start = k;
                    end
                end
                list_id[start]   = id;
                list_cost[start] = cost;
                for (int k = start + 1; k < kbl_pkg::NSLOTS; k++) begin
                    if (ranks_above(k - 1, k)) begin
                        tid              = list_id[k];
                        tcost            = list_cost[k];
                        list_id[k]       = list_id[k - 1];
                        list_cost[k]     = list_cost[k - 1];
                        list_id[k - 1]   = tid;
                        list_cost[k - 1] = tcost;
                    end
                end
                w = '{'0, '0, list_cost[0], 1'b1};
                add_due(w);
            end
            kbl_pkg::MODE_READ: begin
                for (int k = kbl_pkg::K; k >= 1; k--) begin
                    w = '{list_id[k], list_cost[k], list_cost[0], (k == 1)};
                    add_due(w);
                end
            end
            default: begin
                w = '{'0, '0, list_cost[0], 1'b1};
                add_due(w);
            end
        endcase
    endfunction

    function automatic void check_word();
        t_list_word want;
        t_list_word got;
        got = '{out_ch.out_id, out_ch.out_cost, out_ch.worst_cost, out_ch.last};
        if (due_words.size() == 0) begin
            if (fault_count < 10) begin
                $display("Unexpected result word: id=%h cost=%h worst=%h last=%b",
                         got.id, got.cost, got.worst, got.last);
            end
            fault_count++;
            return;
        end
        want = due_words.pop_front();
        if (got !== want) begin
            if (fault_count < 10) begin
                $display("Mismatch: expected id=%h cost=%h worst=%h last=%b", want.id,
                         want.cost, want.worst, want.last);
                $display("          actual   id=%h cost=%h worst=%h last=%b", got.id,
                         got.cost, got.worst, got.last);
            end
            fault_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_cand c;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                apply_word(in_ch.mode, in_ch.item_id, in_ch.item_cost);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_cands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    c = pending_cands.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.mode      <= c.mode;
                    in_ch.item_id   <= c.id;
                    in_ch.item_cost <= c.cost;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) check_word();
            out_ch.ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold_left != 0) rx_hold_left <= rx_hold_left - 1;
    end

    function automatic void queue_cand(kbl_pkg::t_mode mode, kbl_pkg::t_id id,
                                       kbl_pkg::t_cost cost);
        t_cand c;
        c = '{mode, id, cost};
        pending_cands = {pending_cands, c};
        if (mode == kbl_pkg::MODE_INSERT || mode == kbl_pkg::MODE_UPDATE) begin
            issued_ids = {issued_ids, id};
        end
    endfunction

    function automatic kbl_pkg::t_cost pick_cost();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50) return kbl_pkg::t_cost'($urandom_range(0, 24));
        if (r < 85) return kbl_pkg::t_cost'($urandom);
        if (r < 95) return kbl_pkg::INF;
        return '0;
    endfunction

    function automatic kbl_pkg::t_id pick_id();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return kbl_pkg::t_id'($urandom_range(0, 40));
        if (r < 92) return kbl_pkg::t_id'($urandom);
        return kbl_pkg::EMPTY_ID;
    endfunction

    // Mostly well-formed traffic: inserts, updates mostly of ids already issued,
    // readouts, and a few words with the unused mode.
    function automatic void add_random(int count);
        int unsigned  r;
        kbl_pkg::t_id id;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                queue_cand(kbl_pkg::MODE_INSERT, pick_id(), pick_cost());
            end else if (r < 80) begin
                if (issued_ids.size() != 0 && $urandom_range(9) < 7) begin
                    id = issued_ids[$urandom_range(issued_ids.size() - 1)];
                end else if ($urandom_range(3) == 0) begin
                    id = kbl_pkg::EMPTY_ID;
                end else begin
                    id = pick_id();
                end
                queue_cand(kbl_pkg::MODE_UPDATE, id, pick_cost());
            end else if (r < 95) begin
                queue_cand(kbl_pkg::MODE_READ, kbl_pkg::t_id'($urandom),
                           kbl_pkg::t_cost'($urandom));
            end else begin
                queue_cand(MODE_UNUSED, kbl_pkg::t_id'($urandom),
                           kbl_pkg::t_cost'($urandom));
            end
        end
    endfunction

    task automatic drain();
        do @(posedge i_clk);
        while (pending_cands.size() != 0 || in_ch.valid || due_words.size() != 0);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct = idle_pct;
        rx_stall_pct  = stall_pct;
        add_random(count);
        drain();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.mode      = kbl_pkg::MODE_INSERT;
        in_ch.item_id   = '0;
        in_ch.item_cost = '0;
        out_ch.ready    = 1'b0;
        for (int k = 0; k < kbl_pkg::NSLOTS; k++) begin
            list_id[k]   = kbl_pkg::EMPTY_ID;
            list_cost[k] = kbl_pkg::INF;
        end

        // Empty list readout, field extremes, ties, the update special cases,
        // the unused mode, then a full list whose worst entry is updated.
        queue_cand(kbl_pkg::MODE_READ, '0, '0);
        queue_cand(kbl_pkg::MODE_INSERT, 32'd5, 32'd100);
        queue_cand(kbl_pkg::MODE_INSERT, 32'd3, 32'd100);
        queue_cand(kbl_pkg::MODE_INSERT, '0, '0);
        queue_cand(kbl_pkg::MODE_INSERT, 32'hFFFF_FFFE, 32'hFFFF_FFFE);
        queue_cand(kbl_pkg::MODE_INSERT, 32'd7, kbl_pkg::INF);
        queue_cand(kbl_pkg::MODE_UPDATE, 32'd5, 32'd10);
        queue_cand(kbl_pkg::MODE_UPDATE, 32'd3, 32'd5000);
        queue_cand(kbl_pkg::MODE_UPDATE, 32'd99, 32'd50);
        queue_cand(kbl_pkg::MODE_UPDATE, kbl_pkg::EMPTY_ID, 32'd20);
        queue_cand(MODE_UNUSED, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
        for (int i = 0; i < 12; i++) begin
            queue_cand(kbl_pkg::MODE_INSERT, kbl_pkg::t_id'(200 + i),
                       kbl_pkg::t_cost'(200 + i));
        end
        queue_cand(kbl_pkg::MODE_INSERT, 32'd1000, 32'hFFFF_FFF0);
        queue_cand(kbl_pkg::MODE_UPDATE, 32'd1000, 32'd1);
        queue_cand(kbl_pkg::MODE_READ, '1, '1);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain();

        // The sink holds off while the source keeps offering words.
        add_random(20);
        @(posedge i_clk);
        rx_hold_left <= 300;
        drain();

        run_phase(66, 0, 20);
        run_phase(0, 66, 20);
        run_phase(18, 18, 24);

        repeat (2 * kbl_pkg::K + 8) @(posedge i_clk);
        if (fault_count == 0 && due_words.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/kbl_pkg.sv
rtl/kbl_if.sv
rtl/kbl_slot_mem.sv
rtl/k_best_list_insert.sv
test/tb.sv
